>>> rtl/core/assert_macros.svh
// Assertion helpers shared by the marker core modules.
// Needs a clock named clk and a reset named rst in the including scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every clock edge outside reset.
`define UPM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Condition must never be seen outside reset.
`define UPM_NEVER(lbl, cond, msg) \
  `UPM_ASSERT(lbl, !(cond), msg)

`endif

>>> rtl/core/upm_pkg.sv
// Shared types and constants for the unmatched parenthesis marker.
// No dependencies.
`default_nettype none

package upm_pkg;

  localparam int MAX_LEN_DEF = 64;

  localparam logic [7:0] CH_OPEN  = 8'h28;
  localparam logic [7:0] CH_CLOSE = 8'h29;

  localparam logic [1:0] MARK_NONE  = 2'd0;
  localparam logic [1:0] MARK_CLOSE = 2'd1;
  localparam logic [1:0] MARK_OPEN  = 2'd2;

  typedef enum logic [1:0] {
    ST_LOAD,
    ST_BWD,
    ST_EMIT_RD,
    ST_EMIT_OUT
  } upm_state_t;

  typedef struct packed {
    logic load;
    logic bwd_step;
    logic emit_init;
    logic emit_rd;
    logic emit_pop;
  } upm_cmd_t;

  typedef struct packed {
    logic bwd_done;
    logic last_word;
  } upm_stat_t;

endpackage

`default_nettype wire

>>> rtl/core/upm_ctrl.sv
// Controller: load, backward pass and emit sequencing.
// Depends on upm_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module upm_ctrl
  import upm_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      char_valid,
  output logic           char_stall,
  input  wire logic      last_in,
  output logic           result_valid,
  input  wire logic      result_stall,
  input  wire upm_stat_t stat,
  output upm_cmd_t       cmd
);

  upm_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_LOAD;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next   = state;
    cmd          = '0;
    char_stall   = 1'b1;
    result_valid = 1'b0;
    unique case (state)
      ST_LOAD: begin
        char_stall = 1'b0;
        if (char_valid) begin
          cmd.load = 1'b1;
          if (last_in) state_next = ST_BWD;
        end
      end
      ST_BWD: begin
        cmd.bwd_step = 1'b1;
        if (stat.bwd_done) begin
          cmd.emit_init = 1'b1;
          state_next    = ST_EMIT_RD;
        end
      end
      ST_EMIT_RD: begin
        cmd.emit_rd = 1'b1;
        state_next  = ST_EMIT_OUT;
      end
      ST_EMIT_OUT: begin
        result_valid = 1'b1;
        if (!result_stall) begin
          cmd.emit_pop = 1'b1;
          state_next   = stat.last_word ? ST_LOAD : ST_EMIT_RD;
        end
      end
      default: state_next = ST_LOAD;
    endcase
  end

  `UPM_NEVER(a_no_overlap, result_valid && !char_stall, "input open while emitting")
  `UPM_ASSERT(a_hold_out, (result_valid && result_stall) |=> result_valid,
              "result dropped while stalled")

endmodule

`default_nettype wire

>>> rtl/core/upm_dp.sv
// Datapath: byte and mark memories, depth counters, pass pointer.
// Depends on upm_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module upm_dp
  import upm_pkg::*;
#(
  parameter int MAX_LEN = MAX_LEN_DEF
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire upm_cmd_t   cmd,
  output upm_stat_t       stat,
  input  wire logic [7:0] char_in,
  input  wire logic       last_in,
  output logic [7:0]      char_out,
  output logic [1:0]      mark,
  output logic            overflow
);

  localparam int LEN_W  = $clog2(MAX_LEN + 1);
  localparam int ADDR_W = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
  localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(MAX_LEN);

  logic [7:0] char_mem [MAX_LEN];
  logic [1:0] mark_mem [MAX_LEN];

  logic [LEN_W-1:0]  len, open_depth, close_depth, ptr;
  logic              ovf_flag, rd_pend;
  logic [ADDR_W-1:0] bwd_addr;
  logic [7:0]        char_q;
  logic [1:0]        mark_q;

  logic              stored;
  logic [LEN_W-1:0]  len_load, ptr_dec, ptr_inc;
  logic [1:0]        fwd_mark;
  logic [ADDR_W-1:0] rd_addr;
  logic              rd_en;
  logic              char_we, mark_we;
  logic [ADDR_W-1:0] mark_waddr;
  logic [1:0]        mark_wdata;
  logic              bwd_open_hit;

  always_comb begin
    stored   = (len != LEN_MAX);
    len_load = stored ? len + 1'b1 : len;
    ptr_dec  = ptr - 1'b1;
    ptr_inc  = ptr + 1'b1;
    fwd_mark = MARK_NONE;
    if (char_in == CH_CLOSE && open_depth == '0) fwd_mark = MARK_CLOSE;
    rd_addr  = cmd.emit_rd ? ptr[ADDR_W-1:0] : ptr_dec[ADDR_W-1:0];
    rd_en    = cmd.emit_rd || (cmd.bwd_step && ptr != '0);
    bwd_open_hit = cmd.bwd_step && rd_pend && char_q == CH_OPEN && close_depth == '0;
    char_we    = cmd.load && stored;
    mark_we    = char_we || bwd_open_hit;
    mark_waddr = char_we ? len[ADDR_W-1:0] : bwd_addr;
    mark_wdata = char_we ? fwd_mark : MARK_OPEN;
  end

  always_ff @(posedge clk) begin
    if (char_we) char_mem[len[ADDR_W-1:0]] <= char_in;
    if (mark_we) mark_mem[mark_waddr] <= mark_wdata;
    if (rd_en) begin
      char_q <= char_mem[rd_addr];
      mark_q <= mark_mem[rd_addr];
    end
    if (cmd.bwd_step && ptr != '0) bwd_addr <= ptr_dec[ADDR_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      len         <= '0;
      open_depth  <= '0;
      close_depth <= '0;
      ovf_flag    <= 1'b0;
      ptr         <= '0;
      rd_pend     <= 1'b0;
    end else begin
      if (cmd.load) begin
        len <= len_load;
        if (!stored) ovf_flag <= 1'b1;
        if (stored && char_in == CH_OPEN) open_depth <= open_depth + 1'b1;
        if (stored && char_in == CH_CLOSE && open_depth != '0) begin
          open_depth <= open_depth - 1'b1;
        end
        if (last_in) begin
          ptr         <= len_load;
          close_depth <= '0;
          rd_pend     <= 1'b0;
        end
      end
      if (cmd.bwd_step) begin
        rd_pend <= (ptr != '0);
        if (ptr != '0) ptr <= ptr_dec;
        if (rd_pend && char_q == CH_CLOSE) close_depth <= close_depth + 1'b1;
        if (rd_pend && char_q == CH_OPEN && close_depth != '0) begin
          close_depth <= close_depth - 1'b1;
        end
      end
      if (cmd.emit_init) ptr <= '0;
      if (cmd.emit_pop) begin
        if (stat.last_word) begin
          len        <= '0;
          open_depth <= '0;
          ovf_flag   <= 1'b0;
        end else begin
          ptr <= ptr_inc;
        end
      end
    end
  end

  assign stat.bwd_done  = (ptr == '0) && !rd_pend;
  assign stat.last_word = (ptr_inc == len);
  assign char_out = char_q;
  assign mark     = mark_q;
  assign overflow = ovf_flag;

  `UPM_ASSERT(a_emit_in_range, cmd.emit_rd |-> (ptr < len), "emit read past stored length")
  `UPM_ASSERT(a_clear_after_last, (cmd.emit_pop && stat.last_word) |=> (len == '0),
              "length not cleared after final word")
  `UPM_NEVER(a_depth_bound, open_depth > len, "open depth exceeds stored length")

endmodule

`default_nettype wire

>>> rtl/core/unmatched_parenthesis_marker.sv
// Top level of the unmatched parenthesis marker: controller plus datapath.
// Depends on upm_pkg, upm_ctrl and upm_dp.
//
//   channel  | handshake                  | payload
//   ---------+----------------------------+-----------------------------------
//   input    | char_valid / char_stall    | char_in, last_in
//   result   | result_valid / result_stall| char_out, mark, last_out, overflow
//
// Loading takes one cycle per word; the input stalls from the last word on.
// Backward pass: one memory read per cycle, from the last stored word back to the first.
// Emit: for each result word, a memory read into the output register, then the output state.
// Synchronous reset returns to loading with an empty string.
// A stalled result holds its register; nothing advances until it is taken.
`default_nettype none

module unmatched_parenthesis_marker
  import upm_pkg::*;
#(
  parameter int MAX_LEN = MAX_LEN_DEF
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       char_valid,
  output logic            char_stall,
  input  wire logic [7:0] char_in,
  input  wire logic       last_in,
  output logic            result_valid,
  input  wire logic       result_stall,
  output logic [7:0]      char_out,
  output logic [1:0]      mark,
  output logic            last_out,
  output logic            overflow
);

  upm_cmd_t  cmd;
  upm_stat_t stat;

  upm_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .char_valid   (char_valid),
    .char_stall   (char_stall),
    .last_in      (last_in),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .stat         (stat),
    .cmd          (cmd)
  );

  upm_dp #(
    .MAX_LEN (MAX_LEN)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .stat     (stat),
    .char_in  (char_in),
    .last_in  (last_in),
    .char_out (char_out),
    .mark     (mark),
    .overflow (overflow)
  );

  assign last_out = stat.last_word;

endmodule

`default_nettype wire
